// ===== rtl/ilft_pkg.sv =====
package ilft_pkg;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_PREFIX  = 6'b000010,
    PH_COMMAND = 6'b000100,
    PH_PARAMS  = 6'b001000,
    PH_TARGET  = 6'b010000,
    PH_MESSAGE = 6'b100000
  } phase_t;

  // Field tags
  localparam logic [2:0] TAG_DELIM   = 3'd0;
  localparam logic [2:0] TAG_PREFIX  = 3'd1;
  localparam logic [2:0] TAG_COMMAND = 3'd2;
  localparam logic [2:0] TAG_TARGET  = 3'd3;
  localparam logic [2:0] TAG_MESSAGE = 3'd4;
  localparam logic [2:0] TAG_TSPACE  = 3'd5;

  // Event classes; command events follow EV_PRIVMSG in command order
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_ACTION  = 3'd1;
  localparam logic [2:0] EV_PRIVMSG = 3'd2;

  localparam int          NUM_CMDS   = 5;
  localparam logic [2:0]  ACTION_LEN = 3'd7;
  localparam logic [3:0]  CMD_POS_MAX = 4'd15;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SOH   = 8'h01;

  // Result of one byte, parser to output register
  typedef struct packed {
    logic [2:0] field_tag;
    logic       is_nick_byte;
    logic [2:0] event_class;
    logic       nick_present;
  } result_t;

  function automatic logic [3:0] cmd_len(input logic [2:0] k);
    logic [3:0] n;
    begin
      unique case (k)
        3'd0:    n = 4'd7;
        3'd1,
        3'd2,
        3'd3,
        3'd4:    n = 4'd4;
        default: n = 4'd0;
      endcase
      return n;
    end
  endfunction

  function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [2:0] p);
    logic [63:0] w;
    logic [2:0]  sh;
    begin
      unique case (k)
        3'd0:    w = {"PRIVMSG", 8'h00};
        3'd1:    w = {"JOIN", 32'h0};
        3'd2:    w = {"PART", 32'h0};
        3'd3:    w = {"QUIT", 32'h0};
        3'd4:    w = {"NICK", 32'h0};
        default: w = '0;
      endcase
      sh = 3'd7 - p;
      return w[{sh, 3'b000} +: 8];
    end
  endfunction

  function automatic logic [7:0] action_char(input logic [2:0] p);
    logic [63:0] w;
    logic [2:0]  sh;
    begin
      w  = {CH_SOH, "ACTION", 8'h00};
      sh = 3'd7 - p;
      return w[{sh, 3'b000} +: 8];
    end
  endfunction

endpackage

// ===== rtl/ilft_parser.sv =====
module ilft_parser
  import ilft_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [3:0] cmd_pos, cmd_pos_next;
  logic [4:0] cmd_match, cmd_match_next;
  logic [2:0] act_pos, act_pos_next;
  logic       act_matching, act_matching_next;
  logic       bang_seen, bang_seen_next;
  logic       prev_space, prev_space_next;

  logic       cmd_hit;
  logic [2:0] tag;
  logic       nick;
  logic [2:0] ev;

  always_comb begin
    phase_next        = phase;
    cmd_pos_next      = cmd_pos;
    cmd_match_next    = cmd_match;
    act_pos_next      = act_pos;
    act_matching_next = act_matching;
    bang_seen_next    = bang_seen;
    prev_space_next   = prev_space;
    tag               = TAG_DELIM;
    nick              = 1'b0;
    cmd_hit           = 1'b0;

    unique case (phase)
      PH_PREFIX: begin
        if (in_byte == CH_SPACE) begin
          phase_next = PH_COMMAND;
        end else begin
          tag = TAG_PREFIX;
          if (in_byte == CH_BANG) bang_seen_next = 1'b1;
          else if (!bang_seen) nick = 1'b1;
        end
      end
      PH_COMMAND: begin
        if (in_byte == CH_SPACE) begin
          phase_next = PH_PARAMS;
        end else begin
          tag     = TAG_COMMAND;
          cmd_hit = 1'b1;
        end
      end
      PH_PARAMS, PH_TARGET: begin
        if (in_byte == CH_COLON && (phase == PH_PARAMS || prev_space)) begin
          phase_next        = PH_MESSAGE;
          act_matching_next = 1'b1;
          act_pos_next      = '0;
        end else if (in_byte == CH_SPACE) begin
          tag             = TAG_TSPACE;
          prev_space_next = 1'b1;
          phase_next      = PH_TARGET;
        end else begin
          tag             = TAG_TARGET;
          prev_space_next = 1'b0;
          phase_next      = PH_TARGET;
        end
      end
      PH_MESSAGE: begin
        tag = TAG_MESSAGE;
        if (act_matching) begin
          if (act_pos != ACTION_LEN) begin
            if (action_char(act_pos) == in_byte) begin
              act_pos_next = act_pos + 3'd1;
            end else begin
              act_matching_next = 1'b0;
              act_pos_next      = '0;
            end
          end else if (in_byte == CH_SPACE || in_byte == CH_SOH) begin
            // confirmed: hold the position at full length
            act_matching_next = 1'b0;
          end else begin
            act_matching_next = 1'b0;
            act_pos_next      = '0;
          end
        end
      end
      default: begin
        if (in_byte == CH_COLON) begin
          phase_next = PH_PREFIX;
        end else if (in_byte == CH_SPACE) begin
          phase_next = PH_PARAMS;
        end else begin
          tag        = TAG_COMMAND;
          cmd_hit    = 1'b1;
          phase_next = PH_COMMAND;
        end
      end
    endcase

    // drop every command word that this byte does not continue
    if (cmd_hit) begin
      for (int k = 0; k < NUM_CMDS; k++) begin
        if (cmd_pos >= cmd_len(3'(k)) || cmd_char(3'(k), cmd_pos[2:0]) != in_byte)
          cmd_match_next[k] = 1'b0;
      end
      if (cmd_pos != CMD_POS_MAX) cmd_pos_next = cmd_pos + 4'd1;
    end

    // lowest command index wins; action overrides
    ev = EV_NONE;
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      if (cmd_match_next[k] && cmd_pos_next == cmd_len(3'(k)))
        ev = EV_PRIVMSG + 3'(k);
    end
    if (act_pos_next == ACTION_LEN) ev = EV_ACTION;

    res.field_tag    = tag;
    res.is_nick_byte = nick;
    res.event_class  = in_last ? ev : EV_NONE;
    res.nick_present = in_last & bang_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      phase        <= PH_START;
      cmd_pos      <= '0;
      cmd_match    <= '1;
      act_pos      <= '0;
      act_matching <= 1'b0;
      bang_seen    <= 1'b0;
      prev_space   <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      cmd_pos      <= cmd_pos_next;
      cmd_match    <= cmd_match_next;
      act_pos      <= act_pos_next;
      act_matching <= act_matching_next;
      bang_seen    <= bang_seen_next;
      prev_space   <= prev_space_next;
    end
  end

endmodule

// ===== rtl/irc_line_field_tagger_top.sv =====
// IRC line field tagger.
// Input stream (s_*): one byte of an IRC protocol line per request, with
//   s_tlast high on the final byte of the line.
// Output stream (m_*): exactly one request per input byte, in order. The byte
//   comes back with its field tag (delimiter, prefix, command, target, target
//   space, message) and a nick flag for prefix bytes before the first '!'.
//   m_tlast copies the input mark; on that request the event class (action,
//   privmsg, join, part, quit, nick change or none) and the nick-present flag
//   are valid, and both read zero on every other request.
// Path: an accepted byte passes the input register, then the result register,
//   before it can be taken at the output.
// Throughput: one byte per cycle while m_tready stays high; the parse state
//   advances as each byte moves from the input register to the result register.
// Reset (rst, synchronous): empties both registers and returns the parser to
//   line start. After each final byte the parser returns to line start too.
// Stall: while m_tready is low the result holds; one more byte can still be
//   accepted into the input register, after which s_tready drops.
module irc_line_field_tagger_top
  import ilft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] line_byte
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] event_class,
                                 // [11] nick_present, [15:12] zero
  output logic [3:0]  m_tuser,   // [2:0] field_tag, [3] is_nick_byte
  output logic        m_tlast    // last_flag
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // result register payload
  logic [7:0] out_byte;
  result_t    out_res;

  result_t    res;
  logic       out_free;
  logic       advance;
  logic       accept;

  // the result register can load when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // parse state advances only when the byte moves into the result register
  ilft_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= in_byte;
      out_res  <= res;
      m_tlast  <= in_last;
    end
  end

  assign m_tdata = {4'b0000, out_res.nick_present, out_res.event_class, out_byte};
  assign m_tuser = {out_res.is_nick_byte, out_res.field_tag};

endmodule

// ===== rtl/ilft_checker.sv =====
module ilft_checker
  import ilft_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output stall");

  // summary fields are zero except on the final byte
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[11:8] == 4'd0)
    else $error("summary set on a non-final byte");

  // nick bytes are prefix bytes
  a_nick_prefix: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tuser[2:0] == TAG_PREFIX)
    else $error("nick byte outside the prefix");

  // event class and field tag codes in range
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:8] != 3'd7 && m_tuser[2:0] != 3'd6 && m_tuser[2:0] != 3'd7)
    else $error("code out of range");

endmodule

bind irc_line_field_tagger_top ilft_checker u_ilft_checker (.*);
